// ===== rtl/splc_pkg.sv =====
// ----------------------------------------------------------------------------
// splc_pkg: shared types and constants of the stereo peak limiter
// Payload structs, register map, datapath command codes and constant tables.
// ----------------------------------------------------------------------------
package splc_pkg;

  localparam int CFG_ADDR_W = 5;

  localparam logic [23:0] ONE_Q23 = 24'd8388608;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  localparam logic [11:0] HOLD_SHORT = 12'd960;
  localparam logic [11:0] HOLD_LONG  = 12'd2400;
  localparam logic [15:0] ENV_COEF   = 16'd65110;
  localparam logic [16:0] ENV_REST   = 17'd65536 - {1'b0, ENV_COEF};

  localparam logic [2:0] REG_THRESHOLD    = 3'd0;
  localparam logic [2:0] REG_RELEASE_STEP = 3'd1;
  localparam logic [2:0] REG_CLIP_THR     = 3'd2;
  localparam logic [2:0] REG_CLIP_RATIO   = 3'd3;
  localparam logic [2:0] REG_SAT_AMOUNT   = 3'd4;
  localparam logic [2:0] REG_SAT_NORM     = 3'd5;
  localparam logic [2:0] REG_CEILING      = 3'd6;
  localparam logic [2:0] REG_MAKEUP       = 3'd7;

  typedef struct packed {
    logic [23:0] threshold;
    logic [22:0] release_step;
    logic [23:0] clip_threshold;
    logic [16:0] clip_ratio;
    logic [15:0] saturation_amount;
    logic [22:0] saturation_norm;
    logic [23:0] ceiling;
    logic [23:0] makeup_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
  } frame_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } result_t;

  localparam logic [5:0] OP_IDLE  = 6'd0;
  localparam logic [5:0] OP_HOLD  = 6'd1;
  localparam logic [5:0] OP_ENV1  = 6'd2;
  localparam logic [5:0] OP_ENV2  = 6'd3;
  localparam logic [5:0] OP_ENV3  = 6'd4;
  localparam logic [5:0] OP_DIVI  = 6'd5;
  localparam logic [5:0] OP_DIV   = 6'd6;
  localparam logic [5:0] OP_SEEK  = 6'd7;
  localparam logic [5:0] OP_GAIN  = 6'd8;
  localparam logic [5:0] OP_GM1   = 6'd9;
  localparam logic [5:0] OP_GM2   = 6'd10;
  localparam logic [5:0] OP_CH1   = 6'd11;
  localparam logic [5:0] OP_CH2   = 6'd12;
  localparam logic [5:0] OP_LOGI  = 6'd13;
  localparam logic [5:0] OP_NORM  = 6'd14;
  localparam logic [5:0] OP_LSQA  = 6'd15;
  localparam logic [5:0] OP_LSQB  = 6'd16;
  localparam logic [5:0] OP_LOGE  = 6'd17;
  localparam logic [5:0] OP_ER1   = 6'd18;
  localparam logic [5:0] OP_ER2   = 6'd19;
  localparam logic [5:0] OP_BIG   = 6'd20;
  localparam logic [5:0] OP_EXPI  = 6'd21;
  localparam logic [5:0] OP_EXA   = 6'd22;
  localparam logic [5:0] OP_EXB   = 6'd23;
  localparam logic [5:0] OP_EXF1  = 6'd24;
  localparam logic [5:0] OP_EXF2  = 6'd25;
  localparam logic [5:0] OP_CLAMP = 6'd26;
  localparam logic [5:0] OP_SAT1  = 6'd27;
  localparam logic [5:0] OP_SAT2  = 6'd28;
  localparam logic [5:0] OP_SIN1  = 6'd29;
  localparam logic [5:0] OP_SIN2  = 6'd30;
  localparam logic [5:0] OP_SIN3  = 6'd31;
  localparam logic [5:0] OP_SIN4  = 6'd32;
  localparam logic [5:0] OP_HA    = 6'd33;
  localparam logic [5:0] OP_HB    = 6'd34;
  localparam logic [5:0] OP_HC    = 6'd35;
  localparam logic [5:0] OP_HD    = 6'd36;
  localparam logic [5:0] OP_SIN5  = 6'd37;
  localparam logic [5:0] OP_SIN6  = 6'd38;
  localparam logic [5:0] OP_SIN7  = 6'd39;
  localparam logic [5:0] OP_SIN8  = 6'd40;
  localparam logic [5:0] OP_CEIL1 = 6'd41;
  localparam logic [5:0] OP_CEIL2 = 6'd42;
  localparam logic [5:0] OP_DONE  = 6'd43;

  typedef struct packed {
    logic [5:0] op;
    logic [4:0] idx;
    logic       ch;
    logic       sel;
    logic       load;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic ytop;
    logic clip;
    logic bigk;
    logic sat;
  } stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [30:0] exp2_root(input int unsigned idx);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int i = 0; i < 16; i++) begin
      if (i < idx) begin
        c = isqrt64(c << 30);
      end
    end
    return 31'(c);
  endfunction

  localparam logic [30:0] EXP2_ROOT [16] = '{
    exp2_root(1),  exp2_root(2),  exp2_root(3),  exp2_root(4),
    exp2_root(5),  exp2_root(6),  exp2_root(7),  exp2_root(8),
    exp2_root(9),  exp2_root(10), exp2_root(11), exp2_root(12),
    exp2_root(13), exp2_root(14), exp2_root(15), exp2_root(16)
  };

  localparam logic [32:0] H_REC_0 = 33'((64'd1 << 35) / 64'd110);
  localparam logic [32:0] H_REC_1 = 33'((64'd1 << 35) / 64'd72);
  localparam logic [32:0] H_REC_2 = 33'((64'd1 << 35) / 64'd42);
  localparam logic [32:0] H_REC_3 = 33'((64'd1 << 35) / 64'd20);
  localparam logic [32:0] H_REC_4 = 33'((64'd1 << 35) / 64'd6);

  function automatic logic [6:0] h_div(input logic [2:0] i);
    logic [6:0] v;
    case (i)
      3'd0: v = 7'd110;
      3'd1: v = 7'd72;
      3'd2: v = 7'd42;
      3'd3: v = 7'd20;
      default: v = 7'd6;
    endcase
    return v;
  endfunction

  function automatic logic [32:0] h_rec(input logic [2:0] i);
    logic [32:0] v;
    case (i)
      3'd0: v = H_REC_0;
      3'd1: v = H_REC_1;
      3'd2: v = H_REC_2;
      3'd3: v = H_REC_3;
      default: v = H_REC_4;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/splc_regs.sv =====
// ----------------------------------------------------------------------------
// splc_regs: configuration register file
// APB-style write and read access to the eight limiter settings.
// ----------------------------------------------------------------------------
module splc_regs
  import splc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] sel;

  assign sel    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold         <= 24'd8388608;
      cfg.release_step      <= 23'd4194909;
      cfg.clip_threshold    <= 24'd8388608;
      cfg.clip_ratio        <= 17'd65536;
      cfg.saturation_amount <= 16'd0;
      cfg.saturation_norm   <= 23'd4194304;
      cfg.ceiling           <= 24'd8388608;
      cfg.makeup_gain       <= 24'd1048576;
    end else if (psel && penable && pwrite && pready) begin
      unique case (sel)
        REG_THRESHOLD:    cfg.threshold         <= pwdata[23:0];
        REG_RELEASE_STEP: cfg.release_step      <= pwdata[22:0];
        REG_CLIP_THR:     cfg.clip_threshold    <= pwdata[23:0];
        REG_CLIP_RATIO:   cfg.clip_ratio        <= pwdata[16:0];
        REG_SAT_AMOUNT:   cfg.saturation_amount <= pwdata[15:0];
        REG_SAT_NORM:     cfg.saturation_norm   <= pwdata[22:0];
        REG_CEILING:      cfg.ceiling           <= pwdata[23:0];
        REG_MAKEUP:       cfg.makeup_gain       <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_THRESHOLD:    prdata = {8'd0, cfg.threshold};
      REG_RELEASE_STEP: prdata = {9'd0, cfg.release_step};
      REG_CLIP_THR:     prdata = {8'd0, cfg.clip_threshold};
      REG_CLIP_RATIO:   prdata = {15'd0, cfg.clip_ratio};
      REG_SAT_AMOUNT:   prdata = {16'd0, cfg.saturation_amount};
      REG_SAT_NORM:     prdata = {9'd0, cfg.saturation_norm};
      REG_CEILING:      prdata = {8'd0, cfg.ceiling};
      REG_MAKEUP:       prdata = {8'd0, cfg.makeup_gain};
    endcase
  end

endmodule

// ===== rtl/splc_ctrl.sv =====
// ----------------------------------------------------------------------------
// splc_ctrl: limiter sequencer
// Steps the datapath through one frame and owns both channel handshakes.
// ----------------------------------------------------------------------------
module splc_ctrl
  import splc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  frame_valid,
  output logic  frame_ready,
  output logic  result_valid,
  input  logic  result_ready,
  input  stat_t status,
  output cmd_t  cmd
);

  logic [5:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       ch, ch_next;
  logic       sel, sel_next;
  logic       push;

  assign frame_ready = (state == OP_IDLE);
  assign push        = (state == OP_DONE) && (!result_valid || result_ready);

  assign cmd.op   = state;
  assign cmd.idx  = cnt;
  assign cmd.ch   = ch;
  assign cmd.sel  = sel;
  assign cmd.load = frame_valid && frame_ready;
  assign cmd.push = push;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ch_next    = ch;
    sel_next   = sel;
    unique case (state)
      OP_IDLE:  if (frame_valid) state_next = OP_HOLD;
      OP_HOLD:  state_next = OP_ENV1;
      OP_ENV1:  state_next = OP_ENV2;
      OP_ENV2:  state_next = OP_ENV3;
      OP_ENV3:  state_next = OP_DIVI;
      OP_DIVI: begin
        cnt_next   = '0;
        state_next = OP_DIV;
      end
      OP_DIV: begin
        if (cnt == 5'd22) state_next = OP_SEEK;
        else cnt_next = cnt + 5'd1;
      end
      OP_SEEK:  state_next = OP_GAIN;
      OP_GAIN:  state_next = OP_GM1;
      OP_GM1:   state_next = OP_GM2;
      OP_GM2: begin
        ch_next    = 1'b0;
        state_next = OP_CH1;
      end
      OP_CH1:   state_next = OP_CH2;
      OP_CH2: begin
        sel_next   = 1'b0;
        state_next = status.clip ? OP_LOGI : OP_CLAMP;
      end
      OP_LOGI:  state_next = OP_NORM;
      OP_NORM: begin
        if (status.ytop) begin
          cnt_next   = '0;
          state_next = OP_LSQA;
        end
      end
      OP_LSQA:  state_next = OP_LSQB;
      OP_LSQB: begin
        if (cnt == 5'd15) state_next = OP_LOGE;
        else begin
          cnt_next   = cnt + 5'd1;
          state_next = OP_LSQA;
        end
      end
      OP_LOGE: begin
        if (sel) state_next = OP_ER1;
        else begin
          sel_next   = 1'b1;
          state_next = OP_LOGI;
        end
      end
      OP_ER1:   state_next = OP_ER2;
      OP_ER2:   state_next = status.bigk ? OP_BIG : OP_EXPI;
      OP_BIG:   state_next = OP_CLAMP;
      OP_EXPI: begin
        cnt_next   = '0;
        state_next = OP_EXA;
      end
      OP_EXA:   state_next = OP_EXB;
      OP_EXB: begin
        if (cnt == 5'd15) state_next = OP_EXF1;
        else begin
          cnt_next   = cnt + 5'd1;
          state_next = OP_EXA;
        end
      end
      OP_EXF1:  state_next = OP_EXF2;
      OP_EXF2:  state_next = OP_CLAMP;
      OP_CLAMP: state_next = status.sat ? OP_SAT1 : OP_CEIL1;
      OP_SAT1:  state_next = OP_SAT2;
      OP_SAT2:  state_next = OP_SIN1;
      OP_SIN1:  state_next = OP_SIN2;
      OP_SIN2:  state_next = OP_SIN3;
      OP_SIN3:  state_next = OP_SIN4;
      OP_SIN4: begin
        cnt_next   = '0;
        state_next = OP_HA;
      end
      OP_HA:    state_next = OP_HB;
      OP_HB:    state_next = OP_HC;
      OP_HC:    state_next = OP_HD;
      OP_HD: begin
        if (cnt == 5'd4) state_next = OP_SIN5;
        else begin
          cnt_next   = cnt + 5'd1;
          state_next = OP_HA;
        end
      end
      OP_SIN5:  state_next = OP_SIN6;
      OP_SIN6:  state_next = OP_SIN7;
      OP_SIN7:  state_next = OP_SIN8;
      OP_SIN8:  state_next = OP_CEIL1;
      OP_CEIL1: state_next = OP_CEIL2;
      OP_CEIL2: begin
        if (ch) state_next = OP_DONE;
        else begin
          ch_next    = 1'b1;
          state_next = OP_CH1;
        end
      end
      OP_DONE:  if (push) state_next = OP_IDLE;
      default:  state_next = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= OP_IDLE;
      cnt          <= '0;
      ch           <= 1'b0;
      sel          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ch    <= ch_next;
      sel   <= sel_next;
      if (push) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/splc_dp.sv =====
// ----------------------------------------------------------------------------
// splc_dp: limiter datapath
// Limiter state, one shared multiplier, divider, log, exp and sine steps.
// ----------------------------------------------------------------------------
module splc_dp
  import splc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  cmd_t    cmd,
  input  frame_t  frame,
  output stat_t   status,
  output result_t result
);

  logic [23:0] shp, lhp, pkr;
  logic [11:0] shc, lhc;
  logic [31:0] env;
  logic [23:0] gain;

  logic [23:0] lmag, rmag;
  logic        lneg, rneg;
  logic [47:0] acc;
  logic [31:0] level, rem;
  logic [22:0] quo;
  logic        lim;
  logic [23:0] seek;
  logic [27:0] gm;
  logic [47:0] m;
  logic [30:0] y;
  logic [4:0]  kk;
  logic [15:0] f;
  logic [20:0] lc, lv;
  logic [21:0] er;
  logic [23:0] t;
  logic [30:0] x, h;
  logic [31:0] x2, pp;
  logic [23:0] lres, rres;
  logic [65:0] p;

  logic [32:0] ma, mb;
  logic [23:0] lin, rin, pk, shp1, lhp1;
  logic [48:0] env_sum;
  logic [31:0] env_new, pk8, thr8;
  logic [12:0] shc_n, lhc_n;
  logic [32:0] rem2;
  logic [23:0] seek_c, gain_c;
  logic [24:0] g;
  logic [20:0] d;
  logic [31:0] sq;
  logic [23:0] tt;
  logic [30:0] q0, q1;
  logic [39:0] qd;
  logic [31:0] rr;
  logic [4:0]  esh;
  logic [54:0] exf;
  logic [25:0] v;
  logic [23:0] enc;
  logic        cneg;
  logic [23:0] cmag;

  assign lin  = frame.left_in;
  assign rin  = frame.right_in;
  assign pk   = (lmag > rmag) ? lmag : rmag;
  assign shp1 = (pk > shp) ? pk : shp;
  assign lhp1 = (shp1 > lhp) ? shp1 : lhp;

  assign env_sum = {1'b0, acc} + p[48:0];
  assign env_new = env_sum[47:16];
  assign pk8     = {pkr, 8'd0};
  assign thr8    = {cfg.threshold, 8'd0};
  assign shc_n   = {1'b0, shc} + 13'd1;
  assign lhc_n   = {1'b0, lhc} + 13'd1;

  assign rem2   = {rem, 1'b0};
  assign seek_c = lim ? {1'b0, quo} : ONE_Q23;
  assign g      = p[46:22];
  assign gain_c = (gain > seek) ? seek : ((g < {1'b0, seek}) ? g[23:0] : seek);

  assign d    = (lv > lc) ? (lv - lc) : 21'd0;
  assign sq   = p[61:30];
  assign tt   = p[38:15];
  assign esh  = 5'd30 - er[20:16];
  assign exf  = p[54:0] >> esh;

  assign q0 = p[65:35];
  assign qd = 40'(q0) * 40'(h_div(cmd.idx[2:0]));
  assign rr = 32'(40'(pp) - qd);
  assign q1 = (rr >= 32'(h_div(cmd.idx[2:0]))) ? (q0 + 31'd1) : q0;

  assign cneg = cmd.ch ? rneg : lneg;
  assign cmag = cmd.ch ? rmag : lmag;
  assign v    = p[48:23];
  always_comb begin
    if (cneg) enc = (v > 26'(ONE_Q23)) ? ONE_Q23 : 24'(25'h1000000 - 25'(v));
    else enc = (v > 26'(ONE_Q23 - 24'd1)) ? (ONE_Q23 - 24'd1) : v[23:0];
  end

  assign status.ytop = y[30];
  assign status.clip = (cfg.clip_ratio != 17'd65536) && (cfg.clip_threshold != 24'd0) &&
                       (p[50:23] > 28'(cfg.clip_threshold));
  assign status.bigk = (p[37:32] >= 6'd24);
  assign status.sat  = (cfg.saturation_amount != 16'd0);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_ENV1:  begin ma = 33'(ENV_COEF);           mb = 33'(env);                   end
      OP_ENV2:  begin ma = 33'(ENV_REST);           mb = {1'b0, lhp, 8'd0};          end
      OP_SEEK:  begin ma = 33'(gain);               mb = 33'(cfg.release_step);      end
      OP_GM1:   begin ma = 33'(gain);               mb = 33'(cfg.makeup_gain);       end
      OP_CH1:   begin ma = 33'(cmag);               mb = 33'(gm);                    end
      OP_LSQA:  begin ma = 33'(y);                  mb = 33'(y);                     end
      OP_ER1:   begin ma = 33'(d);                  mb = 33'(cfg.clip_ratio);        end
      OP_EXA:   begin ma = 33'(y);                  mb = 33'(EXP2_ROOT[cmd.idx[3:0]]); end
      OP_EXF1:  begin ma = 33'(cfg.clip_threshold); mb = 33'(y);                     end
      OP_SAT1:  begin ma = 33'(m[23:0]);            mb = 33'(cfg.saturation_amount); end
      OP_SIN1:  begin ma = 33'(t);                  mb = 33'(PI_Q30);                end
      OP_SIN3:  begin ma = 33'(x);                  mb = 33'(x);                     end
      OP_HA:    begin ma = 33'(x2);                 mb = 33'(h);                     end
      OP_HC:    begin ma = 33'(pp);                 mb = h_rec(cmd.idx[2:0]);        end
      OP_SIN5:  begin ma = 33'(x);                  mb = 33'(h);                     end
      OP_SIN7:  begin ma = 33'(y);                  mb = 33'(cfg.saturation_norm);   end
      OP_CEIL1: begin ma = 33'(m[25:0]);            mb = 33'(cfg.ceiling);           end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shp  <= '0;
      lhp  <= '0;
      shc  <= '0;
      lhc  <= '0;
      env  <= '0;
      gain <= ONE_Q23;
    end else begin
      unique case (cmd.op)
        OP_HOLD: begin
          shp <= shp1;
          lhp <= lhp1;
        end
        OP_ENV3: begin
          env <= env_new;
          if (shc_n > 13'(HOLD_SHORT)) begin
            shc <= '0;
            shp <= '0;
          end else begin
            shc <= shc_n[11:0];
          end
          if (lhc_n > 13'(HOLD_LONG)) begin
            lhc <= '0;
            lhp <= '0;
          end else begin
            lhc <= lhc_n[11:0];
          end
        end
        OP_GAIN: gain <= gain_c;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
    if (cmd.load) begin
      lneg <= lin[23];
      rneg <= rin[23];
      lmag <= lin[23] ? (~lin + 24'd1) : lin;
      rmag <= rin[23] ? (~rin + 24'd1) : rin;
    end
    if (cmd.push) result <= {lres, rres};
    unique case (cmd.op)
      OP_HOLD:  pkr <= pk;
      OP_ENV2:  acc <= p[47:0];
      OP_ENV3:  level <= (env_new > pk8) ? env_new : pk8;
      OP_DIVI: begin
        rem <= thr8;
        quo <= '0;
        lim <= (level > thr8);
      end
      OP_DIV: begin
        if (rem2 >= {1'b0, level}) begin
          rem <= 32'(rem2 - {1'b0, level});
          quo <= {quo[21:0], 1'b1};
        end else begin
          rem <= rem2[31:0];
          quo <= {quo[21:0], 1'b0};
        end
      end
      OP_SEEK:  seek <= seek_c;
      OP_GM2:   gm <= p[47:20];
      OP_CH2:   m <= 48'(p[50:23]);
      OP_LOGI: begin
        y  <= cmd.sel ? m[30:0] : 31'(cfg.clip_threshold);
        kk <= 5'd30;
        f  <= '0;
      end
      OP_NORM: begin
        if (!y[30]) begin
          y  <= {y[29:0], 1'b0};
          kk <= kk - 5'd1;
        end
      end
      OP_LSQB: begin
        if (sq[31]) begin
          y <= sq[31:1];
          f <= {f[14:0], 1'b1};
        end else begin
          y <= sq[30:0];
          f <= {f[14:0], 1'b0};
        end
      end
      OP_LOGE: begin
        if (cmd.sel) lv <= {kk, f};
        else lc <= {kk, f};
      end
      OP_ER2:   er <= p[37:16];
      OP_BIG:   m <= 48'(ONE_Q23);
      OP_EXPI:  y <= ONE_Q30;
      OP_EXB:   if (er[4'd15 - cmd.idx[3:0]]) y <= p[60:30];
      OP_EXF2:  m <= exf[47:0];
      OP_CLAMP: if (m > 48'(ONE_Q23)) m <= 48'(ONE_Q23);
      OP_SAT2:  t <= (tt > ONE_Q23) ? 24'(25'h1000000 - 25'(tt)) : tt;
      OP_SIN2:  x <= p[54:24];
      OP_SIN4: begin
        x2 <= p[61:30];
        h  <= ONE_Q30;
      end
      OP_HB:    pp <= p[61:30];
      OP_HD:    h <= 31'(32'(ONE_Q30) - 32'(q1));
      OP_SIN6:  y <= p[60:30];
      OP_SIN8:  m <= 48'(p[53:29]);
      OP_CEIL2: begin
        if (cmd.ch) rres <= enc;
        else lres <= enc;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/stereo_peak_limiter_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_limiter_clipper_unit: stereo peak limiter with soft clipper
// Peak hold, envelope, gain computer, soft clip, saturation and ceiling.
// ----------------------------------------------------------------------------
// Usage:
// A stereo frame enters on the frame channel (valid/ready); one limited frame
// leaves on the result channel (valid/ready) for every frame taken. Settings
// are to be written over the APB-style port only while the block is idle;
// this binds the user, and the block itself does not enforce it. Frames are
// worked on one at a time by a sequencer over a single shared multiplier.
// With the soft clipper and saturation bypassed, the 23-step gain divider
// takes the largest part of a frame. With both active, the frame time is set
// by the bit-serial log2 (normalize plus 16 squarings, twice per channel),
// the 16-step exp2 and the sine series. The next frame is accepted while a
// finished result still waits in the output register; a receiver that stalls
// holds the block only when the following result is ready.
// Reset returns all settings to their defaults, clears the peak holds, hold
// counters and envelope, and sets the applied gain to unity.
// ----------------------------------------------------------------------------
module stereo_peak_limiter_clipper_unit
  import splc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_ready,
  input  frame_t                frame,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t status;

  splc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  splc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  splc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .frame  (frame),
    .status (status),
    .result (result)
  );

endmodule
